>>> hdl/ray_segment_nearest_hit_unit_assert.svh
// assertion macros for the ray segment nearest hit unit
`ifndef RAY_SEGMENT_NEAREST_HIT_UNIT_ASSERT_SVH
`define RAY_SEGMENT_NEAREST_HIT_UNIT_ASSERT_SVH
`define RSNH_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("rsnh check failed");
`define RSNH_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("rsnh check failed");
`endif

>>> hdl/rsnh_pkg.sv
// ---------------------------------------------------------------------------
// rsnh_pkg
// shared types and constants of the ray segment nearest hit unit
// ---------------------------------------------------------------------------
package rsnh_pkg;
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_CAST  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [62:0] DIST_MAX = {63{1'b1}};

	typedef enum logic [2:0] {
		OP_MUL_ADD, OP_MUL_SUB
	} mop_t;
endpackage

>>> hdl/rsnh_mul.sv
// ---------------------------------------------------------------------------
// rsnh_mul
// shared signed 34x34 multiplier with registered product
// ---------------------------------------------------------------------------
module rsnh_mul (
	input  logic               clk,
	input  logic signed [33:0] a,
	input  logic signed [33:0] b,
	output logic signed [67:0] p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

>>> hdl/rsnh_div.sv
// ---------------------------------------------------------------------------
// rsnh_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module rsnh_div #(
	parameter int W = 100
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] n_q, d_q, r_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [W:0] sh;
	logic ge;

	assign sh = {r_q, n_q[W-1]};
	assign ge = sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
				n_q <= num;
				d_q <= den;
				r_q <= '0;
			end else if (busy_q) begin
				r_q <= ge ? W'(sh - {1'b0, d_q}) : sh[W-1:0];
				n_q <= {n_q[W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	assign quo = n_q;
endmodule

>>> hdl/ray_segment_nearest_hit_unit.sv
// ---------------------------------------------------------------------------
// ray_segment_nearest_hit_unit
// wall segment store and sequential nearest-hit search for a cast ray
// ---------------------------------------------------------------------------
// a load or clear beat is taken while idle; a cast result beat follows once every
// stored segment is tested, with two divisions for each segment the ray crosses
// flow: no new beat is taken until the result beat has left
// reset: segment count, sequencer and output valid cleared, store not cleared
module ray_segment_nearest_hit_unit #(
	parameter int MAX_SEGMENTS = 256,
	parameter int COORD_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic signed [31:0] x_start,
	input  logic signed [31:0] y_start,
	input  logic signed [31:0] x_end,
	input  logic signed [31:0] y_end,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y,
	output logic [62:0]        dist_sq
);
	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int DW = 100;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_LD, S_MUL, S_ACC, S_CHK, S_PRD, S_DIVX, S_DIVY, S_SQ,
		S_CMP, S_OUT
	} state_t;

	state_t st_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic [4*COORD_WIDTH-1:0] mem [MAX_SEGMENTS];
	logic [4*COORD_WIDTH-1:0] rd_q;
	logic signed [33:0] ax_q, ay_q, bx_q, by_q, c0x, c0y, c1x, c1y;
	logic signed [33:0] ma, mb, rx, ry, sx, sy;
	logic signed [67:0] prod;
	logic signed [68:0] acc_q, cr_q [6];
	logic [3:0] k_q;
	logic [1:0] ph_q;
	logic found_q, div_go_q, div_done, tneg_q, cy_q;
	logic [DW-1:0] div_num, div_den, quo, pn_q;
	logic [DW-1:0] comp_mag, qclip, num_mag;
	logic signed [33:0] comp_r, off;
	logic signed [33:0] ox_q, oy_q;
	logic [67:0] sq_q;
	logic [68:0] best_d_q;
	logic signed [33:0] best_x_q, best_y_q;

	function automatic logic signed [33:0] ext(input logic [31:0] v);
		return 34'(signed'(v[COORD_WIDTH-1:0]));
	endfunction

	function automatic logic [DW-1:0] mag69(input logic signed [68:0] v);
		return DW'(v[68] ? -v : v);
	endfunction

	assign c0x = 34'(signed'(rd_q[COORD_WIDTH-1:0]));
	assign c0y = 34'(signed'(rd_q[2*COORD_WIDTH-1:COORD_WIDTH]));
	assign c1x = 34'(signed'(rd_q[3*COORD_WIDTH-1:2*COORD_WIDTH]));
	assign c1y = 34'(signed'(rd_q[4*COORD_WIDTH-1:3*COORD_WIDTH]));
	assign rx = bx_q - ax_q;
	assign ry = by_q - ay_q;
	assign sx = c1x - c0x;
	assign sy = c1y - c0y;

	assign comp_r = cy_q ? ry : rx;
	assign comp_mag = DW'(comp_r[33] ? -comp_r : comp_r);
	assign num_mag = mag69(cr_q[5]);

	// product schedule: even steps add, odd steps subtract, pairs form crosses
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (k_q)
			4'd0: begin ma = sx; mb = c1y - ay_q; end
			4'd1: begin ma = sy; mb = c1x - ax_q; end
			4'd2: begin ma = sx; mb = c1y - by_q; end
			4'd3: begin ma = sy; mb = c1x - bx_q; end
			4'd4: begin ma = rx; mb = by_q - c1y; end
			4'd5: begin ma = ry; mb = bx_q - c1x; end
			4'd6: begin ma = rx; mb = by_q - c0y; end
			4'd7: begin ma = ry; mb = bx_q - c0x; end
			4'd8: begin ma = rx; mb = sy; end
			4'd9: begin ma = ry; mb = sx; end
			4'd10: begin ma = c0x - ax_q; mb = sy; end
			4'd11: begin ma = c0y - ay_q; mb = sx; end
			4'd12: begin ma = ox_q; mb = ox_q; end
			4'd13: begin ma = oy_q; mb = oy_q; end
			// dividend halves: |r| times low and high parts of |num|
			4'd14: begin ma = {1'b0, comp_mag[32:0]}; mb = {1'b0, num_mag[32:0]}; end
			4'd15: begin ma = {1'b0, comp_mag[32:0]}; mb = {1'b0, num_mag[65:33]}; end
		endcase
	end

	rsnh_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));

	rsnh_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .num(div_num),
		.den(div_den), .done(div_done), .quo(quo)
	);

	logic signed [1:0] q1, q2, q3, q4;
	logic skip;
	function automatic logic signed [1:0] sgn(input logic signed [68:0] v);
		return v[68] ? -2'sd1 : ((v != 0) ? 2'sd1 : 2'sd0);
	endfunction
	assign q1 = sgn(cr_q[0]);
	assign q2 = sgn(cr_q[1]);
	assign q3 = sgn(cr_q[2]);
	assign q4 = sgn(cr_q[3]);
	assign skip = (q1 != 0 && q1 == q2) || (q3 != 0 && q3 == q4) || cr_q[4] == 0;

	assign div_num = pn_q;
	assign div_den = mag69(cr_q[4]);
	assign qclip = (quo > comp_mag) ? comp_mag : quo;
	assign off = (comp_r[33] != tneg_q) ? -34'(qclip) : 34'(qclip);

	assign in_stall = (st_q != S_IDLE);

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_valid && mode == rsnh_pkg::MODE_LOAD
			&& cnt_q < CW'(MAX_SEGMENTS))
			mem[cnt_q[AW-1:0]] <= {y_end[COORD_WIDTH-1:0], x_end[COORD_WIDTH-1:0],
				y_start[COORD_WIDTH-1:0], x_start[COORD_WIDTH-1:0]};
		if (st_q == S_RD)
			rd_q <= mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			out_valid <= 1'b0;
			div_go_q <= 1'b0;
			k_q <= '0;
		end else begin
			div_go_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_valid) begin
					unique case (mode)
						rsnh_pkg::MODE_LOAD:
							if (cnt_q < CW'(MAX_SEGMENTS)) cnt_q <= cnt_q + 1'b1;
						rsnh_pkg::MODE_CLEAR: cnt_q <= '0;
						rsnh_pkg::MODE_CAST: begin
							ax_q <= ext(x_start);
							ay_q <= ext(y_start);
							bx_q <= ext(x_end);
							by_q <= ext(y_end);
							idx_q <= '0;
							found_q <= 1'b0;
							st_q <= (cnt_q == 0) ? S_OUT : S_RD;
						end
						default: ;
					endcase
				end
				S_RD: st_q <= S_LD;
				S_LD: begin k_q <= 4'd0; st_q <= S_MUL; end
				S_MUL: begin
					// product of step k-1 arrives now
					if (k_q[0]) acc_q <= 69'(prod);
					else if (k_q != 0) cr_q[3'(k_q[3:1] - 3'd1)] <= acc_q - 69'(prod);
					if (k_q == 4'd11) st_q <= S_ACC;
					else k_q <= k_q + 1'b1;
				end
				S_ACC: begin
					cr_q[5] <= acc_q - 69'(prod);
					st_q <= S_CHK;
				end
				S_CHK: begin
					if (skip) st_q <= S_CMP;
					else begin
						tneg_q <= (cr_q[5][68] != cr_q[4][68]) && cr_q[5] != 0;
						cy_q <= 1'b0;
						k_q <= 4'd14;
						ph_q <= 2'd0;
						st_q <= S_PRD;
					end
				end
				S_PRD: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd0) k_q <= 4'd15;
					if (ph_q == 2'd1) pn_q <= DW'(prod);
					if (ph_q == 2'd2) begin
						pn_q <= pn_q + (DW'(prod) << 33);
						div_go_q <= 1'b1;
						st_q <= cy_q ? S_DIVY : S_DIVX;
					end
				end
				S_DIVX: if (div_done) begin
					ox_q <= off;
					cy_q <= 1'b1;
					k_q <= 4'd14;
					ph_q <= 2'd0;
					st_q <= S_PRD;
				end
				S_DIVY: if (div_done) begin
					oy_q <= off;
					k_q <= 4'd12;
					ph_q <= 2'd0;
					st_q <= S_SQ;
				end
				S_SQ: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd0) k_q <= 4'd13;
					if (ph_q == 2'd1) sq_q <= 68'(prod);
					if (ph_q == 2'd2) begin
						if (!found_q || 69'(sq_q) + 69'(prod) < best_d_q) begin
							found_q <= 1'b1;
							best_d_q <= 69'(sq_q) + 69'(prod);
							best_x_q <= ax_q + ox_q;
							best_y_q <= ay_q + oy_q;
						end
						st_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (idx_q + 1'b1 >= cnt_q) st_q <= S_OUT;
					else st_q <= S_RD;
					idx_q <= idx_q + 1'b1;
				end
				S_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						hit <= found_q;
						hit_x <= found_q ? best_x_q[31:0] : '0;
						hit_y <= found_q ? best_y_q[31:0] : '0;
						dist_sq <= !found_q ? '0 :
							(best_d_q[68:63] != 0 ? rsnh_pkg::DIST_MAX : best_d_q[62:0]);
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> hdl/rsnh_checker.sv
// ---------------------------------------------------------------------------
// rsnh_checker
// port-level checks of the ray segment nearest hit unit
// ---------------------------------------------------------------------------
`include "ray_segment_nearest_hit_unit_assert.svh"
module rsnh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        hit,
	input logic [31:0] hit_x,
	input logic [62:0] dist_sq
);
	`RSNH_ASSERT_IMP(a_busy_out, out_valid, in_stall)
	`RSNH_ASSERT_IMP(a_miss_zero, out_valid && !hit, hit_x == 0 && dist_sq == 0)
	`RSNH_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(dist_sq))
endmodule

bind ray_segment_nearest_hit_unit rsnh_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .hit(hit), .hit_x(hit_x),
	.dist_sq(dist_sq)
);

>>> dv/ray_segment_nearest_hit_unit_tb.sv
// ---------------------------------------------------------------------------
// ray_segment_nearest_hit_unit_tb
// drives segment loads, clears and ray casts into the unit under random
// handshake idling, predicts the nearest hit of every cast from its own copy
// of the segment store in wide exact arithmetic and checks each result beat
// ---------------------------------------------------------------------------
module ray_segment_nearest_hit_unit_tb;

	localparam int NSEG = 256;
	localparam int LIMIT = 8000000;
	localparam logic [1:0] MODE_NONE = 2'd3;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [62:0]        d;
	} hit_t;

	class scoreboard_t;
		longint sx0[NSEG], sy0[NSEG], sx1[NSEG], sy1[NSEG];
		int unsigned nseg;
		hit_t hits_due[$];
		int errors;

		function new();
			nseg = 0;
			errors = 0;
		endfunction

		function wide_t xprod(longint ux, longint uy, longint vx, longint vy);
			wide_t a, b, c, d;
			a = ux; b = vy; c = uy; d = vx;
			return a * b - c * d;
		endfunction

		function int sgn(wide_t v);
			return v < 0 ? -1 : (v > 0 ? 1 : 0);
		endfunction

		function longint scale(longint r, wide_t num, wide_t den, bit tneg);
			wide_t mr, an, ad, q;
			mr = r < 0 ? -r : r;
			an = num < 0 ? -num : num;
			ad = den < 0 ? -den : den;
			q = (mr * an) / ad;
			if (q > mr) q = mr;
			return ((r < 0) != tneg) ? -longint'(q) : longint'(q);
		endfunction

		function void note_beat(logic [1:0] m, logic signed [31:0] ax_i, ay_i,
				bx_i, by_i);
			longint ax, ay, bx, by, rx, ry, sx, sy, ox, oy;
			wide_t den, num, sq, best;
			bit found, tneg;
			hit_t e;
			ax = ax_i; ay = ay_i; bx = bx_i; by = by_i;
			if (m == rsnh_pkg::MODE_LOAD) begin
				if (nseg < NSEG) begin
					sx0[nseg] = ax; sy0[nseg] = ay; sx1[nseg] = bx; sy1[nseg] = by;
					nseg++;
				end
				return;
			end
			if (m == rsnh_pkg::MODE_CLEAR) begin
				nseg = 0;
				return;
			end
			if (m != rsnh_pkg::MODE_CAST) return;
			rx = bx - ax;
			ry = by - ay;
			found = 0;
			best = 0;
			e = '0;
			for (int i = 0; i < nseg; i++) begin
				sx = sx1[i] - sx0[i];
				sy = sy1[i] - sy0[i];
				if (sgn(xprod(sx, sy, sx1[i] - ax, sy1[i] - ay)) *
						sgn(xprod(sx, sy, sx1[i] - bx, sy1[i] - by)) > 0) continue;
				if (sgn(xprod(rx, ry, bx - sx1[i], by - sy1[i])) *
						sgn(xprod(rx, ry, bx - sx0[i], by - sy0[i])) > 0) continue;
				den = xprod(rx, ry, sx, sy);
				if (den == 0) continue;
				num = xprod(sx0[i] - ax, sy0[i] - ay, sx, sy);
				tneg = ((num < 0) != (den < 0)) && num != 0;
				ox = scale(rx, num, den, tneg);
				oy = scale(ry, num, den, tneg);
				sq = wide_t'(ox) * wide_t'(ox) + wide_t'(oy) * wide_t'(oy);
				if (!found || sq < best) begin
					found = 1;
					best = sq;
					e.hit = 1;
					e.x = 32'(ax + ox);
					e.y = 32'(ay + oy);
					e.d = (best > wide_t'(rsnh_pkg::DIST_MAX)) ? rsnh_pkg::DIST_MAX
						: best[62:0];
				end
			end
			hits_due = {hits_due, e};
		endfunction

		function void check_beat(hit_t got);
			hit_t e;
			if (hits_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %p", got);
				return;
			end
			e = hits_due.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp %0b %0d %0d %0d, got %0b %0d %0d %0d",
						e.hit, e.x, e.y, e.d, got.hit, got.x, got.y, got.d);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         mode;
	logic signed [31:0] x_start, y_start, x_end, y_end;
	logic               out_valid;
	logic               out_stall;
	logic               hit;
	logic signed [31:0] hit_x, hit_y;
	logic [62:0]        dist_sq;

	scoreboard_t sb = new();
	bit calm;
	int cycles;

	ray_segment_nearest_hit_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .x_start(x_start), .y_start(y_start),
		.x_end(x_end), .y_end(y_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .hit_x(hit_x), .hit_y(hit_y), .dist_sq(dist_sq)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// beat monitors and receiver idling
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_beat(mode, x_start, y_start, x_end, y_end);
			if (out_valid && !out_stall) sb.check_beat({hit, hit_x, hit_y, dist_sq});
		end
		out_stall <= (!arst_n || calm) ? 1'b0 : ($urandom_range(99) < 38);
	end

	function automatic logic signed [31:0] q16(int v);
		return v <<< 16;
	endfunction

	task automatic send(logic [1:0] m, logic signed [31:0] ax, ay, bx, by);
		if (!calm && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		x_start <= ax; y_start <= ay; x_end <= bx; y_end <= by;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_small(logic [1:0] m, int lim);
		send(m, $urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
			$urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.hits_due.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	initial begin
		int sent;
		arst_n = 0;
		in_valid = 0;
		mode = rsnh_pkg::MODE_LOAD;
		x_start = 0; y_start = 0; x_end = 0; y_end = 0;
		calm = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty store, plain hit, equal distance, parallel, degenerate
		send(rsnh_pkg::MODE_CAST, 0, 0, q16(10), 0);
		send(rsnh_pkg::MODE_LOAD, q16(10), q16(-5), q16(10), q16(5));
		send(rsnh_pkg::MODE_LOAD, q16(5), q16(-5), q16(15), q16(5));
		send(rsnh_pkg::MODE_LOAD, q16(3), q16(-5), q16(3), q16(5));
		send(rsnh_pkg::MODE_CAST, q16(20), 0, q16(-20), 0);
		send(rsnh_pkg::MODE_CAST, 0, 0, q16(20), 0);
		send(rsnh_pkg::MODE_CAST, 0, 0, 0, 0);
		send(rsnh_pkg::MODE_CAST, q16(10), q16(-8), q16(10), q16(8));
		send(rsnh_pkg::MODE_LOAD, q16(1), q16(1), q16(1), q16(1));
		send(rsnh_pkg::MODE_CAST, 0, q16(-2), q16(2), q16(4));
		send(MODE_NONE, 0, 0, q16(20), 0);
		send(rsnh_pkg::MODE_CLEAR, 0, 0, 0, 0);
		send(rsnh_pkg::MODE_CAST, 0, 0, q16(20), 0);
		// extremes of the coordinate range
		send(rsnh_pkg::MODE_LOAD, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh8000_0000);
		send(rsnh_pkg::MODE_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh7fff_ffff);
		send(rsnh_pkg::MODE_CAST, 32'sh8000_0000, 0, 32'sh7fff_ffff, 32'sh0000_0001);
		send(rsnh_pkg::MODE_CAST, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh8000_0000);
		send(rsnh_pkg::MODE_CAST, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh8000_0000);
		send(rsnh_pkg::MODE_CLEAR, -1, -1, -1, -1);
		// fill the store past full; only the first segment lies on the first ray
		send(rsnh_pkg::MODE_LOAD, q16(50), q16(-5), q16(50), q16(5));
		for (int i = 1; i < NSEG + 2; i++)
			send(rsnh_pkg::MODE_LOAD, q16(100 + i), q16(100), q16(101 + i), q16(110));
		send(rsnh_pkg::MODE_CAST, 0, 0, q16(60), 0);
		send(rsnh_pkg::MODE_CAST, q16(200), q16(105), q16(600), q16(106));
		send(rsnh_pkg::MODE_CLEAR, 0, 0, 0, 0);
		drain();

		sent = 0;
		while (sent < 120) begin
			calm = (sent >= 40 && sent < 80);
			if (sent >= 100 && sent < 104) drain();
			if ($urandom_range(99) < 80) begin
				if (sb.nseg > 24 || $urandom_range(1)) begin
					send(rsnh_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
					sent++;
				end
				repeat ($urandom_range(1, 8)) begin
					send_small(rsnh_pkg::MODE_LOAD, 1 << 20);
					sent++;
				end
				repeat ($urandom_range(1, 4)) begin
					send_small(rsnh_pkg::MODE_CAST, 1 << 21);
					sent++;
				end
			end else begin
				send(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
				sent++;
			end
		end
		drain();
		if (sb.errors == 0 && sb.hits_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
